/* rtl/core/sghp_pkg.sv */
package sghp_pkg;

  localparam int NET_SLOTS_DEF  = 4096;
  localparam int PART_MAX_DEF   = 16;
  localparam int DEGREE_MAX_DEF = 64;
  localparam int SIZE_BITS_DEF  = 20;

  localparam int CAP_W  = 28;
  localparam int PIU_W  = 5;
  localparam int NET_W  = 12;
  localparam int OUT_PW = 4;

  localparam logic [27:0] CAP_RESET = 28'd16384;
  localparam logic [4:0]  PIU_RESET = 5'd16;

  localparam int REG_CAPACITY  = 0;
  localparam int REG_PARTITION = 1;

  // Running best candidate handed from cell to cell.
  typedef struct packed {
    logic        valid;
    logic [5:0]  idx;
    logic [63:0] score;
    logic [31:0] size;
  } cand_t;

endpackage

/* rtl/core/sghp_cell.sv */
module sghp_cell #(
  parameter int SIZE_BITS = sghp_pkg::SIZE_BITS_DEF,
  parameter int CNT_W     = 7,
  parameter logic [5:0] MY_IDX = 6'd0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clr_conn,
  input  logic                 conn_inc,
  input  logic                 size_inc,
  input  logic                 enabled,
  input  logic [27:0]          capacity_q8,
  input  sghp_pkg::cand_t      cand_in,
  output sghp_pkg::cand_t      cand_out
);

  logic [SIZE_BITS-1:0] size;
  logic [CNT_W-1:0]     conn;
  logic signed [41:0]   room;
  logic signed [63:0]   score;
  logic                 take;

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= '0;
      conn <= '0;
    end else begin
      if (clr_conn) begin
        conn <= '0;
      end else if (conn_inc) begin
        conn <= conn + 1'b1;
      end
      if (size_inc && size != {SIZE_BITS{1'b1}}) begin
        size <= size + 1'b1;
      end
    end
  end

  // The shift by eight keeps the room in Q.8 like the capacity.
  assign room  = $signed({14'd0, capacity_q8}) - $signed({2'd0, 40'(size) << 8});
  assign score = 64'(room * $signed({1'b0, conn}));

  always_comb begin
    take = 1'b0;
    if (enabled) begin
      if (!cand_in.valid) begin
        take = 1'b1;
      end else if ($signed(score) > $signed(cand_in.score)) begin
        take = 1'b1;
      end else if (score == cand_in.score && 32'(size) < cand_in.size) begin
        take = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cand_out.valid <= 1'b1;
      cand_out.idx   <= MY_IDX;
      cand_out.score <= score;
      cand_out.size  <= 32'(size);
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

/* rtl/core/streaming_greedy_hypergraph_partitioner_top.sv */
// Channel   Signals                                  Direction
// input     start, busy, net_id, has_net, last       in (busy out)
// result    done, chosen_partition, degree_overflow  out, one-cycle strobe
// config    psel, penable, pwrite, paddr, pwdata,    APB write/read
//           prdata, pready
//
// An item without last passes through start, a membership read, and a count
// update into the partition cells. An item with last then lets the candidate
// ripple through the chain of cells, does a read-modify-write for each buffered
// net, and finishes by emitting the result. After reset the membership memory
// is cleared one net per cycle while busy stays high. The receiver cannot
// stall the result.
module streaming_greedy_hypergraph_partitioner_top #(
  parameter int NET_SLOTS  = sghp_pkg::NET_SLOTS_DEF,
  parameter int PART_MAX   = sghp_pkg::PART_MAX_DEF,
  parameter int DEGREE_MAX = sghp_pkg::DEGREE_MAX_DEF,
  parameter int SIZE_BITS  = sghp_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] net_id,
  input  logic        has_net,
  input  logic        last,
  output logic        done,
  output logic [3:0]  chosen_partition,
  output logic        degree_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW   = (NET_SLOTS > 1) ? $clog2(NET_SLOTS) : 1;
  localparam int DW   = $clog2(DEGREE_MAX);
  localparam int CW   = $clog2(DEGREE_MAX + 1);
  localparam int PW   = $clog2(PART_MAX);
  localparam int PCW  = $clog2(PART_MAX + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_COUNT = 3'd3;
  localparam logic [2:0] S_CHAIN = 3'd4;
  localparam logic [2:0] S_WRD   = 3'd5;
  localparam logic [2:0] S_WWR   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state;
  logic [27:0] capacity_q8;
  logic [4:0]  partitions_in_use;

  logic [PART_MAX-1:0] mem [NET_SLOTS];
  logic [PART_MAX-1:0] rd_data;
  logic [NW-1:0] rd_addr;
  logic [NW-1:0] wr_addr;
  logic [PART_MAX-1:0] wr_data;
  logic wr_en;

  logic [NW-1:0] vnets [DEGREE_MAX];
  logic [NW-1:0] vnet_rd;
  logic [CW-1:0] net_count;
  logic [CW-1:0] wb_k;
  logic overflow_seen;
  logic last_q;
  logic has_q;
  logic [NW-1:0] net_q;
  logic [NW:0] clr_ptr;
  logic [PCW-1:0] chain_cnt;
  logic [PCW-1:0] parts;
  logic [PW-1:0] best;

  sghp_pkg::cand_t chain [PART_MAX+1];

  assign pready = 1'b1;
  assign busy = (state != S_IDLE);

  always_comb begin
    parts = PCW'(partitions_in_use);
    if (partitions_in_use == 5'd0) begin
      parts = PCW'(1);
    end else if (32'(partitions_in_use) > PART_MAX) begin
      parts = PCW'(PART_MAX);
    end
  end

  always_comb begin
    prdata = '0;
    case (32'(paddr[2]))
      sghp_pkg::REG_CAPACITY:  prdata = {4'd0, capacity_q8};
      sghp_pkg::REG_PARTITION: prdata = {27'd0, partitions_in_use};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_q8 <= sghp_pkg::CAP_RESET;
      partitions_in_use <= sghp_pkg::PIU_RESET;
    end else if (psel && penable && pwrite) begin
      case (32'(paddr[2]))
        sghp_pkg::REG_CAPACITY:  capacity_q8 <= pwdata[27:0];
        sghp_pkg::REG_PARTITION: partitions_in_use <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Membership memory: one read and one write port, registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && has_net && net_count < CW'(DEGREE_MAX)) begin
      vnets[net_count[DW-1:0]] <= NW'(net_id);
    end
    vnet_rd <= vnets[wb_k[DW-1:0]];
  end

  always_comb begin
    rd_addr = net_q;
    if (state == S_WRD || state == S_WWR) begin
      rd_addr = vnet_rd;
    end
    wr_en = 1'b0;
    wr_addr = vnet_rd;
    wr_data = rd_data | (PART_MAX'(1) << best);
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = clr_ptr[NW-1:0];
      wr_data = '0;
    end else if (state == S_WWR) begin
      wr_en = 1'b1;
    end
  end

  assign chain[0] = '0;

  for (genvar p = 0; p < PART_MAX; p++) begin : g_cell
    sghp_cell #(
      .SIZE_BITS(SIZE_BITS),
      .CNT_W    (CW),
      .MY_IDX   (6'(p))
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .clr_conn   (state == S_EMIT),
      .conn_inc   (state == S_COUNT && has_q && rd_data[p]),
      .size_inc   (state == S_EMIT && best == PW'(p)),
      .enabled    (PCW'(p) < parts),
      .capacity_q8(capacity_q8),
      .cand_in    (chain[p]),
      .cand_out   (chain[p+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_ptr <= '0;
      net_count <= '0;
      overflow_seen <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == (NW+1)'(NET_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            last_q <= last;
            net_q <= NW'(net_id);
            has_q <= 1'b0;
            if (has_net) begin
              if (net_count < CW'(DEGREE_MAX)) begin
                has_q <= 1'b1;
                net_count <= net_count + 1'b1;
              end else begin
                overflow_seen <= 1'b1;
              end
            end
            state <= S_READ;
          end
        end
        S_READ: state <= S_COUNT;
        S_COUNT: begin
          chain_cnt <= '0;
          wb_k <= '0;
          state <= last_q ? S_CHAIN : S_IDLE;
        end
        S_CHAIN: begin
          chain_cnt <= chain_cnt + 1'b1;
          if (chain_cnt == PCW'(PART_MAX)) begin
            best <= chain[PART_MAX].idx[PW-1:0];
            state <= S_WRD;
          end
        end
        S_WRD: begin
          // vnet_rd is valid for wb_k; memory read lands next cycle.
          if (wb_k == net_count) begin
            state <= S_EMIT;
          end else begin
            wb_k <= wb_k + 1'b1;
            state <= S_WWR;
          end
        end
        S_WWR: begin
          state <= S_WRD;
        end
        S_EMIT: begin
          done <= 1'b1;
          chosen_partition <= 4'(best);
          degree_overflow <= overflow_seen;
          net_count <= '0;
          overflow_seen <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
